// File: hw/rtl/srsm_pkg.sv
// Package for the step response settle monitor: types, codes and constants.
`timescale 1ns / 1ps
`default_nettype none
package srsm_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_TARGET_POSITION   = 2'd0;
  localparam logic [1:0] CFG_MAX_MOTION_MS     = 2'd1;
  localparam logic [1:0] CFG_SETTLE_WINDOW_MS  = 2'd2;
  localparam logic [1:0] CFG_SETTLE_VOLTAGE_MV = 2'd3;

  // Reset values of the configuration registers
  localparam logic [31:0] TARGET_POSITION_RST   = 32'd0;
  localparam logic [15:0] MAX_MOTION_MS_RST     = 16'd5000;
  localparam logic [15:0] SETTLE_WINDOW_MS_RST  = 16'd100;
  localparam logic [13:0] SETTLE_VOLTAGE_MV_RST = 14'd500;

  // Input command codes
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Speed scale: position change per ms to per second
  localparam int unsigned SPEED_SCALE = 1000;
  // Dividend width: 32 bit magnitude times a 10 bit scale
  localparam int unsigned DIV_W       = 42;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

  localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;
  localparam logic [15:0] SAT16 = 16'hFFFF;

  typedef enum logic [1:0] {
    RUN_ACTIVE  = 2'd0,
    RUN_SETTLED = 2'd1,
    RUN_TIMEOUT = 2'd2
  } run_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_MUL,
    ST_DIV,
    ST_UPDATE,
    ST_PUBLISH
  } state_e;

endpackage
`default_nettype wire

// File: hw/rtl/step_response_settle_monitor_top.sv
// Top level of the step response settle monitor: sequencer, restoring divider and statistics.
`timescale 1ns / 1ps
`default_nettype none
// Watches one step response of a two-sided drive. A start word (cmd 0) records the start
// time, position and error sign and clears all statistics; each sample word (cmd 1) updates
// peak absolute speed, peak absolute position, error sign crossings and the settle detector.
// Every input word yields exactly one result word with the current statistics. The block
// takes one word at a time: a start word, a sample after the run has ended, or a timed-out
// sample goes from the calculate step straight to publish; a processed sample passes through
// the multiply and update steps, and through the divider when its elapsed time since the
// previous sample is nonzero. The divider is a restoring divider that forms one quotient bit
// per cycle of |position change| * 1000 / elapsed ms. The input is ready again in the cycle
// after the result is loaded. A finished result sits in an output register, so the next
// word is accepted while the previous result still waits; it is only moved out once that
// register is free. Configuration writes are taken in any cycle (cfg_ready_o is tied high)
// and must only be issued while the block is idle.
module step_response_settle_monitor_top #(
  parameter int unsigned STOPS_REQUIRED = 3
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               cmd_i,
  input  wire logic [31:0]        time_ms_i,
  input  wire logic signed [31:0] position_i,
  input  wire logic signed [14:0] left_voltage_mv_i,
  input  wire logic signed [14:0] right_voltage_mv_i,
  // output channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [30:0]             peak_speed_o,
  output logic [30:0]             peak_abs_position_o,
  output logic [15:0]             crossing_count_o,
  output logic [31:0]             settle_time_ms_o,
  output logic                    done_res_o,
  output logic                    timed_out_o
);
  import srsm_pkg::*;

  localparam int unsigned CntW = (STOPS_REQUIRED > 1) ? $clog2(STOPS_REQUIRED + 1) : 1;
  localparam logic [CntW:0] StopsReq = (CntW + 1)'(STOPS_REQUIRED);

  // Sequencer
  state_e state_q, state_d;

  // Configuration registers
  logic [31:0] target_q;
  logic [15:0] max_motion_q;
  logic [15:0] window_ms_q;
  logic [13:0] volt_thr_q;

  // Captured input word
  logic        cmd_q;
  logic [31:0] time_q;
  logic [31:0] pos_q;
  logic [14:0] vl_abs_q, vr_abs_q;

  // Run state
  logic [31:0] start_time_q, start_time_d;
  logic [31:0] prev_time_q, prev_time_d;
  logic [31:0] prev_pos_q, prev_pos_d;
  logic        prev_neg_q, prev_neg_d;
  logic [31:0] qstart_q, qstart_d;
  logic        qflag_q, qflag_d;
  logic [CntW-1:0] qcnt_q, qcnt_d;
  logic [30:0] peak_speed_q, peak_speed_d;
  logic [30:0] peak_pos_q, peak_pos_d;
  logic [15:0] cross_q, cross_d;
  logic [31:0] settle_q, settle_d;
  run_e        run_q, run_d;

  // Divider
  logic [31:0]          diff_q, diff_d;
  logic [31:0]          dt_q, dt_d;
  logic [31:0]          rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  // Output register
  logic out_valid_q;

  logic in_acc, out_free;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;

  // Shared arithmetic terms
  logic [31:0] elapsed;
  logic        timeout_hit;
  logic [32:0] err_ext;
  logic        err_neg;
  logic [32:0] pdiff;
  logic [32:0] pdiff_abs;
  logic [31:0] pos_abs;
  logic [30:0] pos_sat;
  logic [32:0] rem_sh;
  logic        rem_ge;
  logic [30:0] speed_sat;
  logic        quiet;
  logic [31:0] win_elapsed;
  logic [CntW:0] qcnt_inc;

  assign elapsed     = time_q - start_time_q;
  assign timeout_hit = elapsed >= {16'd0, max_motion_q};
  assign err_ext     = {pos_q[31], pos_q} - {target_q[31], target_q};
  assign err_neg     = err_ext[32];
  assign pdiff       = {pos_q[31], pos_q} - {prev_pos_q[31], prev_pos_q};
  assign pdiff_abs   = pdiff[32] ? (33'd0 - pdiff) : pdiff;
  assign pos_abs     = pos_q[31] ? (32'd0 - pos_q) : pos_q;
  // Only the most negative position has magnitude 2^31; clamp it
  assign pos_sat     = pos_abs[31] ? SAT31 : pos_abs[30:0];
  assign rem_sh      = {rem_q, quo_q[DIV_W-1]};
  assign rem_ge      = rem_sh >= {1'b0, dt_q};
  assign speed_sat   = (|quo_q[DIV_W-1:31]) ? SAT31 : quo_q[30:0];
  assign quiet       = (vl_abs_q < {1'b0, volt_thr_q}) && (vr_abs_q < {1'b0, volt_thr_q});
  assign win_elapsed = time_q - qstart_q;
  assign qcnt_inc    = {1'b0, qcnt_q} + (CntW + 1)'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_CALC;
      end
      ST_CALC: begin
        if (cmd_q == CMD_START || run_q != RUN_ACTIVE || timeout_hit) begin
          state_d = ST_PUBLISH;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = (dt_q == 32'd0) ? ST_UPDATE : ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == DIV_LAST) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = ST_PUBLISH;
      end
      ST_PUBLISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath updates per sequencer step
  always_comb begin
    start_time_d = start_time_q;
    prev_time_d  = prev_time_q;
    prev_pos_d   = prev_pos_q;
    prev_neg_d   = prev_neg_q;
    qstart_d     = qstart_q;
    qflag_d      = qflag_q;
    qcnt_d       = qcnt_q;
    peak_speed_d = peak_speed_q;
    peak_pos_d   = peak_pos_q;
    cross_d      = cross_q;
    settle_d     = settle_q;
    run_d        = run_q;
    diff_d       = diff_q;
    dt_d         = dt_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    cnt_d        = cnt_q;
    case (state_q)
      ST_CALC: begin
        diff_d = pdiff_abs[31:0];
        dt_d   = time_q - prev_time_q;
        if (cmd_q == CMD_START) begin
          // Restart the run from this word
          start_time_d = time_q;
          prev_time_d  = time_q;
          prev_pos_d   = pos_q;
          prev_neg_d   = err_neg;
          qstart_d     = 32'd0;
          qflag_d      = 1'b0;
          qcnt_d       = '0;
          peak_speed_d = '0;
          peak_pos_d   = '0;
          cross_d      = '0;
          settle_d     = '0;
          run_d        = RUN_ACTIVE;
        end else if (run_q == RUN_ACTIVE && timeout_hit) begin
          run_d = RUN_TIMEOUT;
        end
      end
      ST_MUL: begin
        // Load the scaled magnitude as dividend
        quo_d = DIV_W'(diff_q) * DIV_W'(SPEED_SCALE);
        rem_d = '0;
        cnt_d = '0;
      end
      ST_DIV: begin
        rem_d = rem_ge ? 32'(rem_sh - {1'b0, dt_q}) : rem_sh[31:0];
        quo_d = {quo_q[DIV_W-2:0], rem_ge};
        cnt_d = cnt_q + DIV_CNT_W'(1);
      end
      ST_UPDATE: begin
        if (dt_q != 32'd0 && speed_sat > peak_speed_q) peak_speed_d = speed_sat;
        if (pos_sat > peak_pos_q) peak_pos_d = pos_sat;
        if (err_neg != prev_neg_q && cross_q != SAT16) cross_d = cross_q + 16'd1;
        prev_neg_d  = err_neg;
        prev_pos_d  = pos_q;
        prev_time_d = time_q;
        if (quiet) begin
          if (!qflag_q) begin
            // Open the first window
            qstart_d = time_q;
            qflag_d  = 1'b1;
          end else if (win_elapsed >= {16'd0, window_ms_q}) begin
            qcnt_d = qcnt_inc[CntW-1:0];
            if (qcnt_inc >= StopsReq) begin
              settle_d = elapsed;
              run_d    = RUN_SETTLED;
            end else begin
              qstart_d = time_q;
            end
          end
        end else begin
          // Loud sample: drop the window
          qstart_d = 32'd0;
          qflag_d  = 1'b0;
          qcnt_d   = '0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      target_q     <= TARGET_POSITION_RST;
      max_motion_q <= MAX_MOTION_MS_RST;
      window_ms_q  <= SETTLE_WINDOW_MS_RST;
      volt_thr_q   <= SETTLE_VOLTAGE_MV_RST;
      start_time_q <= '0;
      prev_time_q  <= '0;
      prev_pos_q   <= '0;
      prev_neg_q   <= 1'b0;
      qstart_q     <= '0;
      qflag_q      <= 1'b0;
      qcnt_q       <= '0;
      peak_speed_q <= '0;
      peak_pos_q   <= '0;
      cross_q      <= '0;
      settle_q     <= '0;
      run_q        <= RUN_ACTIVE;
    end else begin
      state_q      <= state_d;
      start_time_q <= start_time_d;
      prev_time_q  <= prev_time_d;
      prev_pos_q   <= prev_pos_d;
      prev_neg_q   <= prev_neg_d;
      qstart_q     <= qstart_d;
      qflag_q      <= qflag_d;
      qcnt_q       <= qcnt_d;
      peak_speed_q <= peak_speed_d;
      peak_pos_q   <= peak_pos_d;
      cross_q      <= cross_d;
      settle_q     <= settle_d;
      run_q        <= run_d;
      if (state_q == ST_PUBLISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_TARGET_POSITION:   target_q     <= cfg_data_i;
          CFG_MAX_MOTION_MS:     max_motion_q <= cfg_data_i[15:0];
          CFG_SETTLE_WINDOW_MS:  window_ms_q  <= cfg_data_i[15:0];
          CFG_SETTLE_VOLTAGE_MV: volt_thr_q   <= cfg_data_i[13:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers: captured word, divider and result
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q    <= cmd_i;
      time_q   <= time_ms_i;
      pos_q    <= position_i;
      // |v| of a 15 bit value; the most negative code gives 2^14
      vl_abs_q <= left_voltage_mv_i[14]  ? 15'(15'd0 - left_voltage_mv_i)  : left_voltage_mv_i;
      vr_abs_q <= right_voltage_mv_i[14] ? 15'(15'd0 - right_voltage_mv_i) : right_voltage_mv_i;
    end
    diff_q <= diff_d;
    dt_q   <= dt_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
    if (state_q == ST_PUBLISH && out_free) begin
      peak_speed_o        <= peak_speed_q;
      peak_abs_position_o <= peak_pos_q;
      crossing_count_o    <= cross_q;
      settle_time_ms_o    <= settle_q;
      done_res_o          <= (run_q != RUN_ACTIVE);
      timed_out_o         <= (run_q == RUN_TIMEOUT);
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/srsm_checker.sv
// Port-level checker for the step response settle monitor and its bind.
`timescale 1ns / 1ps
`default_nettype none
module srsm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [30:0] peak_speed_o,
  input wire logic [31:0] settle_time_ms_o,
  input wire logic        done_res_o,
  input wire logic        timed_out_o
);

  // One word at a time: drop ready right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted back to back");

  // A timed-out run is always a finished run
  a_timeout_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && timed_out_o) |-> done_res_o)
    else $error("timed_out without done_res");

  // A timed-out run never reports a settle time
  a_timeout_no_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && timed_out_o) |-> (settle_time_ms_o == 32'd0))
    else $error("settle time reported on timeout");

  // Hold a stalled result
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(peak_speed_o)))
    else $error("stalled result changed");

endmodule

bind step_response_settle_monitor_top srsm_checker u_srsm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .peak_speed_o     (peak_speed_o),
  .settle_time_ms_o (settle_time_ms_o),
  .done_res_o       (done_res_o),
  .timed_out_o      (timed_out_o)
);
`default_nettype wire

// File: test/step_response_settle_monitor_top_tb.sv
// Self-checking testbench for the step response settle monitor top level.
`timescale 1ns / 1ps
module step_response_settle_monitor_top_tb;
  import srsm_pkg::*;

  localparam int STOPS = 3;

  // One result word as the block presents it
  typedef struct packed {
    logic [30:0] peak_speed;
    logic [30:0] peak_pos;
    logic [15:0] crossings;
    logic [31:0] settle_ms;
    logic        done;
    logic        timed_out;
  } stats_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [31:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic cmd_i;
  logic [31:0] time_ms_i;
  logic signed [31:0] position_i;
  logic signed [14:0] left_voltage_mv_i;
  logic signed [14:0] right_voltage_mv_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [30:0] peak_speed_o;
  logic [30:0] peak_abs_position_o;
  logic [15:0] crossing_count_o;
  logic [31:0] settle_time_ms_o;
  logic done_res_o;
  logic timed_out_o;

  step_response_settle_monitor_top #(
    .STOPS_REQUIRED(STOPS)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .cmd_i              (cmd_i),
    .time_ms_i          (time_ms_i),
    .position_i         (position_i),
    .left_voltage_mv_i  (left_voltage_mv_i),
    .right_voltage_mv_i (right_voltage_mv_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .peak_speed_o       (peak_speed_o),
    .peak_abs_position_o(peak_abs_position_o),
    .crossing_count_o   (crossing_count_o),
    .settle_time_ms_o   (settle_time_ms_o),
    .done_res_o         (done_res_o),
    .timed_out_o        (timed_out_o)
  );

  // Configuration as the block should hold it
  logic signed [31:0] cfg_target;
  logic [15:0]        cfg_timeout_ms;
  logic [15:0]        cfg_window_ms;
  logic [13:0]        cfg_quiet_mv;

  // Monitor state as the block should hold it
  logic [31:0]        run_start_ms;
  logic [31:0]        last_ms;
  logic signed [31:0] last_pos;
  logic               last_err_neg;
  logic [31:0]        window_open_ms;
  logic               window_open;
  logic [1:0]         windows_done;
  logic [30:0]        top_speed;
  logic [30:0]        top_pos;
  logic [15:0]        sign_flips;
  logic [31:0]        settle_at_ms;
  run_e               run_state;

  stats_t expected_stats[$];

  bit in_idle_on;
  bit out_idle_on;
  int n_mismatch;
  int words_sent;
  int words_checked;
  int runs_settled;
  int runs_timed_out;

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #30_000_000;
    $display("step_response_settle_monitor_top test failed");
    $finish;
  end

  function automatic void flag(input string what, input longint unsigned want,
                               input longint unsigned got);
    if (n_mismatch < 10) begin
      $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $realtime);
    end
    n_mismatch++;
  endfunction

  function automatic void reset_monitor();
    cfg_target     = TARGET_POSITION_RST;
    cfg_timeout_ms = MAX_MOTION_MS_RST;
    cfg_window_ms  = SETTLE_WINDOW_MS_RST;
    cfg_quiet_mv   = SETTLE_VOLTAGE_MV_RST;
    run_start_ms   = '0;
    last_ms        = '0;
    last_pos       = '0;
    last_err_neg   = 1'b0;
    window_open_ms = '0;
    window_open    = 1'b0;
    windows_done   = '0;
    top_speed      = '0;
    top_pos        = '0;
    sign_flips     = '0;
    settle_at_ms   = '0;
    run_state      = RUN_ACTIVE;
  endfunction

  // Advance the monitor by one word and return the statistics it should report
  function automatic stats_t advance_monitor(input logic cmd, input logic [31:0] now,
                                             input logic signed [31:0] pos,
                                             input logic signed [14:0] vl,
                                             input logic signed [14:0] vr);
    stats_t s;
    longint delta;
    longint unsigned mag;
    longint unsigned rate;
    logic [31:0] dt;
    int lv;
    int rv;
    int q;
    logic neg;
    neg = (longint'(pos) - longint'(cfg_target)) < 0;
    if (cmd == CMD_START) begin
      run_start_ms   = now;
      last_ms        = now;
      last_pos       = pos;
      last_err_neg   = neg;
      window_open_ms = '0;
      window_open    = 1'b0;
      windows_done   = '0;
      top_speed      = '0;
      top_pos        = '0;
      sign_flips     = '0;
      settle_at_ms   = '0;
      run_state      = RUN_ACTIVE;
    end else if (run_state == RUN_ACTIVE) begin
      if (32'(now - run_start_ms) >= {16'd0, cfg_timeout_ms}) begin
        run_state = RUN_TIMEOUT;
        runs_timed_out++;
      end else begin
        dt = now - last_ms;
        if (dt != 0) begin
          delta = longint'(pos) - longint'(last_pos);
          mag   = (delta < 0) ? -delta : delta;
          rate  = (mag * 64'd1000) / {32'd0, dt};
          if (rate > 64'h7FFF_FFFF) rate = 64'h7FFF_FFFF;
          if (rate > {33'd0, top_speed}) top_speed = rate[30:0];
        end
        mag = (pos < 0) ? -longint'(pos) : longint'(pos);
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        if (mag > {33'd0, top_pos}) top_pos = mag[30:0];
        if (neg != last_err_neg && sign_flips != 16'hFFFF) sign_flips++;
        last_err_neg = neg;
        last_pos     = pos;
        last_ms      = now;
        lv = int'(vl);
        rv = int'(vr);
        if (lv < 0) lv = -lv;
        if (rv < 0) rv = -rv;
        q = int'(cfg_quiet_mv);
        if (lv < q && rv < q) begin
          if (!window_open) begin
            window_open_ms = now;
            window_open    = 1'b1;
          end else if (32'(now - window_open_ms) >= {16'd0, cfg_window_ms}) begin
            windows_done++;
            if (windows_done >= STOPS) begin
              // settled: the window start is left as it was
              settle_at_ms = now - run_start_ms;
              run_state    = RUN_SETTLED;
              runs_settled++;
            end else begin
              window_open_ms = now;
            end
          end
        end else begin
          window_open_ms = '0;
          window_open    = 1'b0;
          windows_done   = '0;
        end
      end
    end
    s.peak_speed = top_speed;
    s.peak_pos   = top_pos;
    s.crossings  = sign_flips;
    s.settle_ms  = settle_at_ms;
    s.done       = (run_state != RUN_ACTIVE);
    s.timed_out  = (run_state == RUN_TIMEOUT);
    return s;
  endfunction

  // Send one word; returns right after the edge that accepted it, valid still high
  task automatic send_word(input logic cmd, input logic [31:0] now, input logic [31:0] pos,
                           input int vl, input int vr);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 11) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i         = 1'b1;
    cmd_i              = cmd;
    time_ms_i          = now;
    position_i         = pos;
    left_voltage_mv_i  = 15'(vl);
    right_voltage_mv_i = 15'(vr);
    do @(posedge clk_i); while (!in_ready_o);
    expected_stats.push_back(advance_monitor(cmd, now, pos, 15'(vl), 15'(vr)));
    words_sent++;
  endtask

  // Drop valid, wait for every pending result, then let the block settle
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_stats.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // Only called while the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_TARGET_POSITION:   cfg_target     = val;
      CFG_MAX_MOTION_MS:     cfg_timeout_ms = val[15:0];
      CFG_SETTLE_WINDOW_MS:  cfg_window_ms  = val[15:0];
      CFG_SETTLE_VOLTAGE_MV: cfg_quiet_mv   = val[13:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic int any_volt();
    int v;
    v = $urandom_range(0, 24000);
    return v - 12000;
  endfunction

  function automatic int quiet_volt();
    int q;
    int m;
    q = int'(cfg_quiet_mv);
    if (q == 0) return 0;
    m = $urandom_range(0, q - 1);
    return ($urandom_range(0, 1) != 0) ? -m : m;
  endfunction

  // Samples before any start, full-scale positions, zero elapsed, speed saturation
  task automatic test_reset_state();
    send_word(CMD_SAMPLE, 32'd100, 32'h0001_0000, 12000, -12000);
    send_word(CMD_SAMPLE, 32'd100, 32'h8000_0000, -12000, 12000);
    send_word(CMD_SAMPLE, 32'd101, 32'h7FFF_FFFF, 0, 0);
  endtask

  // Three quiet windows across a time wrap, with a loud sample at the threshold
  task automatic test_quiet_windows();
    logic [31:0] t0;
    drain_results();
    t0 = 32'hFFFF_FF00;
    send_word(CMD_START,  t0,         32'h0002_0000, 9000, 9000);
    send_word(CMD_SAMPLE, t0 + 10,    32'hFFFF_F000, 499, -499);
    send_word(CMD_SAMPLE, t0 + 50,    32'h0000_0100, 0, 0);
    send_word(CMD_SAMPLE, t0 + 110,   32'h0000_0080, -1, 1);
    send_word(CMD_SAMPLE, t0 + 150,   32'hFFFF_FF80, 500, 0);
    send_word(CMD_SAMPLE, t0 + 160,   32'h0000_0010, 0, -300);
    send_word(CMD_SAMPLE, t0 + 260,   32'h0000_0008, 200, 0);
    send_word(CMD_SAMPLE, t0 + 360,   32'h0000_0004, 0, 0);
    send_word(CMD_SAMPLE, t0 + 460,   32'h0000_0002, 0, 0);
    // the run has ended: this one must be ignored
    send_word(CMD_SAMPLE, t0 + 470,   32'h4000_0000, 12000, 12000);
  endtask

  // Zero window: settling confirmed in the same ms as the start
  task automatic test_settle_at_start();
    int k;
    drain_results();
    write_reg(CFG_SETTLE_WINDOW_MS, 32'd0);
    send_word(CMD_START, 32'd1234, 32'h0000_0000, 0, 0);
    for (k = 0; k < 4; k++) send_word(CMD_SAMPLE, 32'd1234, 32'h0000_0100, 0, 0);
  endtask

  // Zero and largest timeout, restart during a run, extreme target and threshold
  task automatic test_timeouts();
    drain_results();
    write_reg(CFG_MAX_MOTION_MS, 32'd0);
    send_word(CMD_START,  32'd50, 32'h0000_1000, 0, 0);
    send_word(CMD_SAMPLE, 32'd50, 32'h0000_2000, 0, 0);
    drain_results();
    write_reg(CFG_MAX_MOTION_MS, 32'd65535);
    write_reg(CFG_SETTLE_WINDOW_MS, 32'd65535);
    write_reg(CFG_TARGET_POSITION, 32'h8000_0000);
    write_reg(CFG_SETTLE_VOLTAGE_MV, 32'd12000);
    send_word(CMD_START,  32'd5,           32'h0000_0000, 0, 0);
    send_word(CMD_SAMPLE, 32'd5 + 65534,   32'hFFFF_FFFF, 11999, -11999);
    send_word(CMD_START,  32'd200,         32'h7FFF_FFFF, -12000, 12000);
    send_word(CMD_SAMPLE, 32'd200 + 65535, 32'h0000_0000, 0, 0);
  endtask

  // Flip the error sign on every sample at full rate with no idle cycles
  task automatic test_crossing_burst();
    int k;
    drain_results();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    write_reg(CFG_TARGET_POSITION, 32'h7FFF_FFFF);
    write_reg(CFG_TARGET_POSITION, 32'd0);
    write_reg(CFG_MAX_MOTION_MS, 32'd5000);
    write_reg(CFG_SETTLE_VOLTAGE_MV, 32'd0);
    send_word(CMD_START, 32'd7, 32'h0000_0001, 0, 0);
    for (k = 0; k < 30; k++) begin
      send_word(CMD_SAMPLE, 32'd7, (k % 2 == 0) ? 32'hFFFF_FFFF : 32'h0000_0001, 0, 0);
    end
  endtask

  // One step response: start away from target, ring around it, calm down
  task automatic run_step_response(input int n_samples);
    logic [31:0] t;
    longint off;
    int r;
    int nz;
    int k;
    int loud_pct;
    t   = $urandom;
    r   = $urandom_range(0, 1 << 21);
    off = r - (1 << 20);
    send_word(CMD_START, t, cfg_target + off[31:0], any_volt(), any_volt());
    for (k = 0; k < n_samples; k++) begin
      if ($urandom_range(0, 9) == 0) t = t;
      else t = t + $urandom_range(1, 30);
      r   = $urandom_range(2, 8);
      nz  = $urandom_range(0, 64);
      off = -(off * r) / 10 + nz - 32;
      loud_pct = 80 - (160 * k) / n_samples;
      if (loud_pct < 5) loud_pct = 5;
      if ($urandom_range(0, 99) < loud_pct) begin
        send_word(CMD_SAMPLE, t, cfg_target + off[31:0], any_volt(), any_volt());
      end else begin
        send_word(CMD_SAMPLE, t, cfg_target + off[31:0], quiet_volt(), quiet_volt());
      end
    end
  endtask

  // Random phases: fresh settings, mostly step responses, some noise words
  task automatic test_random_runs();
    int ph;
    int cnt;
    int n;
    logic [31:0] val;
    for (ph = 0; ph < 5; ph++) begin
      drain_results();
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0: val = 32'h8000_0000;
        1: val = 32'h7FFF_FFFF;
        2: val = $urandom;
        default: val = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
      endcase
      write_reg(CFG_TARGET_POSITION, val);
      case ($urandom_range(0, 7))
        0: val = 32'd0;
        1: val = 32'd65535;
        default: val = $urandom_range(150, 1500);
      endcase
      write_reg(CFG_MAX_MOTION_MS, val);
      case ($urandom_range(0, 7))
        0: val = 32'd0;
        1: val = 32'd65535;
        default: val = $urandom_range(1, 60);
      endcase
      write_reg(CFG_SETTLE_WINDOW_MS, val);
      case ($urandom_range(0, 7))
        0: val = 32'd0;
        1: val = 32'd12000;
        default: val = $urandom_range(1, 3000);
      endcase
      write_reg(CFG_SETTLE_VOLTAGE_MV, val);
      cnt = 0;
      while (cnt < 65) begin
        if ($urandom_range(0, 9) == 0) begin
          send_word(1'($urandom_range(0, 1)), $urandom, $urandom, any_volt(), any_volt());
          cnt++;
        end else begin
          n = $urandom_range(8, 25);
          run_step_response(n);
          cnt += n + 1;
        end
      end
    end
  endtask

  // Result side: stall at random, compare each word with the oldest expectation
  initial begin : result_checker
    stats_t got;
    stats_t want;
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = out_idle_on ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.peak_speed = peak_speed_o;
      got.peak_pos   = peak_abs_position_o;
      got.crossings  = crossing_count_o;
      got.settle_ms  = settle_time_ms_o;
      got.done       = done_res_o;
      got.timed_out  = timed_out_o;
      words_checked++;
      if (expected_stats.size() == 0) begin
        flag("result word with nothing pending", '0, 64'(got));
      end else begin
        want = expected_stats.pop_front();
        if (got.peak_speed !== want.peak_speed) flag("peak_speed", 64'(want.peak_speed),
                                                     64'(got.peak_speed));
        if (got.peak_pos !== want.peak_pos) flag("peak_abs_position", 64'(want.peak_pos),
                                                 64'(got.peak_pos));
        if (got.crossings !== want.crossings) flag("crossing_count", 64'(want.crossings),
                                                   64'(got.crossings));
        if (got.settle_ms !== want.settle_ms) flag("settle_time_ms", 64'(want.settle_ms),
                                                   64'(got.settle_ms));
        if (got.done !== want.done) flag("done_res", 64'(want.done), 64'(got.done));
        if (got.timed_out !== want.timed_out) flag("timed_out", 64'(want.timed_out),
                                                   64'(got.timed_out));
      end
    end
  end

  // Main sequence: reset once, run each test in turn, then judge
  initial begin
    rst_ni             = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_index_i        = '0;
    cfg_data_i         = '0;
    in_valid_i         = 1'b0;
    cmd_i              = CMD_START;
    time_ms_i          = '0;
    position_i         = '0;
    left_voltage_mv_i  = '0;
    right_voltage_mv_i = '0;
    in_idle_on         = 1'b1;
    out_idle_on        = 1'b1;
    n_mismatch         = 0;
    words_sent         = 0;
    words_checked      = 0;
    runs_settled       = 0;
    runs_timed_out     = 0;
    reset_monitor();
    // hold reset low, then release it on a falling edge
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_quiet_windows();
    test_settle_at_start();
    test_timeouts();
    test_crossing_burst();
    test_random_runs();
    drain_results();

    if (expected_stats.size() != 0) flag("result words never delivered",
                                         '0, 64'(expected_stats.size()));
    $display("Covered %0d words (%0d result words checked) over directed and random runs,",
             words_sent, words_checked);
    $display("%0d runs settled, %0d runs timed out, %0d mismatches.",
             runs_settled, runs_timed_out, n_mismatch);
    if (n_mismatch == 0) begin
      $display("step_response_settle_monitor_top test passed");
    end else begin
      $display("step_response_settle_monitor_top test failed");
    end
    $finish;
  end

endmodule
